// ----- hdl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property holds on every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk_s, rst_s, prop)
`define ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ----- hdl/msq_pkg.sv -----
// shared constants, codes and the controller to datapath command struct
`default_nettype none

package msq_pkg;

    localparam int MAX_SIZE   = 64;
    localparam int IDX_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int ADDR_W     = 12;
    localparam int CNT_W      = 13;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT   = 2'd2;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_LOADED = 2'd1,
        STATUS_RANGE_DONE = 2'd2
    } status_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              setup;
        logic              issue;
        logic              k_first;
        logic              k_last;
        logic              row_end;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        logic [SIZE_W-1:0] size;
        logic              emit_status;
        status_t           status;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/msq_ctrl.sv -----
// controller: configuration registers, load bookkeeping and row sequencing
`default_nettype none
`include "assert_macros.svh"

module msq_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            kind,
    input  wire logic                            cfg_valid,
    input  wire logic [msq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [msq_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 busy,
    output msq_pkg::dp_cmd_t                     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [msq_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [msq_pkg::SIZE_W-1:0]      limit_reg, limit_next;
    logic [msq_pkg::CNT_W-1:0]       load_count_reg, load_count_next;
    logic [msq_pkg::SIZE_W-1:0]      next_row_reg, next_row_next;
    logic                            ready_reg, ready_next;
    logic [msq_pkg::IDX_W-1:0]       row_reg, row_next;
    logic [msq_pkg::SIZE_W-1:0]      n_reg, n_next;
    logic [msq_pkg::IDX_W-1:0]       j_reg, j_next;
    logic [msq_pkg::IDX_W-1:0]       k_reg, k_next;
    logic                            drain_reg, drain_next;

    logic [msq_pkg::SIZE_W-1:0]      eff_size;
    logic [msq_pkg::CNT_W-1:0]       total;
    logic [msq_pkg::SIZE_W-1:0]      end_row;
    logic [msq_pkg::CNT_W-1:0]       load_idx;
    logic                            k_at_end;
    logic                            j_at_end;

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = msq_pkg::SIZE_W'(1);
        end
        else if (size_reg > msq_pkg::SIZE_W'(msq_pkg::MAX_SIZE))
        begin
            eff_size = msq_pkg::SIZE_W'(msq_pkg::MAX_SIZE);
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    assign total    = msq_pkg::CNT_W'(eff_size) * msq_pkg::CNT_W'(eff_size);
    assign end_row  = (limit_reg < eff_size) ? limit_reg : eff_size;
    // a finished matrix restarts the store on the next load
    assign load_idx = (ready_reg || (load_count_reg >= total)) ? '0 : load_count_reg;
    assign k_at_end = ({1'b0, k_reg} == (n_reg - msq_pkg::SIZE_W'(1)));
    assign j_at_end = ({1'b0, j_reg} == (n_reg - msq_pkg::SIZE_W'(1)));
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        limit_next      = limit_reg;
        load_count_next = load_count_reg;
        next_row_next   = next_row_reg;
        ready_next      = ready_reg;
        row_next        = row_reg;
        n_next          = n_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        drain_next      = drain_reg;

        cmd             = '0;
        cmd.wr_addr     = load_idx[msq_pkg::ADDR_W-1:0];
        cmd.row         = row_reg;
        cmd.size        = n_reg;
        cmd.col         = j_reg;
        cmd.k_first     = (k_reg == '0);
        cmd.k_last      = k_at_end;
        cmd.row_end     = j_at_end;
        cmd.status      = msq_pkg::STATUS_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == msq_pkg::KIND_LOAD)
                    begin
                        cmd.wr_en       = 1'b1;
                        load_count_next = load_idx + msq_pkg::CNT_W'(1);
                        ready_next      = (load_idx + msq_pkg::CNT_W'(1)) >= total;
                    end
                    else if (!ready_reg)
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status      = msq_pkg::STATUS_NOT_LOADED;
                    end
                    else if (next_row_reg >= end_row)
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status      = msq_pkg::STATUS_RANGE_DONE;
                    end
                    else
                    begin
                        row_next      = next_row_reg[msq_pkg::IDX_W-1:0];
                        n_next        = eff_size;
                        next_row_next = next_row_reg + msq_pkg::SIZE_W'(1);
                        j_next        = '0;
                        k_next        = '0;
                        state_next    = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (k_at_end)
                begin
                    k_next = '0;
                    if (j_at_end)
                    begin
                        drain_next = 1'b0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + msq_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + msq_pkg::IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // wait out the product and accumulate stages
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            unique case (cfg_index)
                msq_pkg::CFG_MATRIX_SIZE:
                begin
                    size_next       = cfg_data;
                    load_count_next = '0;
                    ready_next      = 1'b0;
                end
                msq_pkg::CFG_FIRST_ROW:
                begin
                    next_row_next = {1'b0, cfg_data[msq_pkg::IDX_W-1:0]};
                end
                msq_pkg::CFG_ROW_LIMIT:
                begin
                    limit_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_reg       <= msq_pkg::SIZE_W'(msq_pkg::MAX_SIZE);
            limit_reg      <= msq_pkg::SIZE_W'(msq_pkg::MAX_SIZE);
            load_count_reg <= '0;
            next_row_reg   <= '0;
            ready_reg      <= 1'b0;
            row_reg        <= '0;
            n_reg          <= msq_pkg::SIZE_W'(1);
            j_reg          <= '0;
            k_reg          <= '0;
            drain_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            limit_reg      <= limit_next;
            load_count_reg <= load_count_next;
            next_row_reg   <= next_row_next;
            ready_reg      <= ready_next;
            row_reg        <= row_next;
            n_reg          <= n_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            drain_reg      <= drain_next;
        end
    end

    `ASSERT_IMPLY(a_ready_means_full, clk, rst_n, ready_reg, load_count_reg == total)
    `ASSERT_HOLDS(a_count_bounded, clk, rst_n, load_count_reg <= total)
    `ASSERT_IMPLY(a_run_in_range, clk, rst_n, state_reg == ST_RUN,
                  ({1'b0, k_reg} < n_reg) && ({1'b0, j_reg} < n_reg))

endmodule

`default_nettype wire

// ----- hdl/msq_datapath.sv -----
// datapath: element store, multiply-accumulate pipeline and result registers
`default_nettype none
`include "assert_macros.svh"

module msq_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire msq_pkg::dp_cmd_t                   cmd,
    input  wire logic signed [msq_pkg::ELEM_W-1:0]  element,
    output logic                                    strobe,
    output logic [msq_pkg::IDX_W-1:0]               row_index,
    output logic [msq_pkg::IDX_W-1:0]               column_index,
    output logic signed [msq_pkg::SUM_W-1:0]        product_sum,
    output logic                                    last,
    output msq_pkg::status_t                        status
);

    logic [msq_pkg::ELEM_W-1:0] mem [msq_pkg::MAX_SIZE*msq_pkg::MAX_SIZE];

    logic [msq_pkg::ADDR_W-1:0]         row_base_reg;
    logic [msq_pkg::ADDR_W-1:0]         ptr_a_reg, ptr_b_reg;
    logic [msq_pkg::ADDR_W-1:0]         addr_a, addr_b;
    logic [msq_pkg::CNT_W-1:0]          row_base_next;
    logic signed [msq_pkg::ELEM_W-1:0]  rd_a_reg, rd_b_reg;

    logic                               s1_valid_reg, s2_valid_reg;
    logic                               s1_first_reg, s2_first_reg;
    logic                               s1_last_reg, s2_last_reg;
    logic                               s1_end_reg, s2_end_reg;
    logic [msq_pkg::IDX_W-1:0]          s1_col_reg, s2_col_reg;
    logic signed [msq_pkg::PROD_W-1:0]  prod_reg;
    logic signed [msq_pkg::SUM_W-1:0]   acc_reg;
    logic signed [msq_pkg::SUM_W-1:0]   sum;

    logic                               strobe_reg;
    logic [msq_pkg::IDX_W-1:0]          row_index_reg;
    logic [msq_pkg::IDX_W-1:0]          column_index_reg;
    logic signed [msq_pkg::SUM_W-1:0]   product_sum_reg;
    logic                               last_reg;
    msq_pkg::status_t                   status_reg;

    assign row_base_next = msq_pkg::CNT_W'(cmd.row) * msq_pkg::CNT_W'(cmd.size);

    // row walks along by one, column walks down by n
    assign addr_a = cmd.k_first ? row_base_reg : ptr_a_reg + msq_pkg::ADDR_W'(1);
    assign addr_b = cmd.k_first ? msq_pkg::ADDR_W'(cmd.col)
                                : ptr_b_reg + msq_pkg::ADDR_W'(cmd.size);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= element;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    assign sum = (s2_first_reg ? '0 : acc_reg)
               + {{(msq_pkg::SUM_W-msq_pkg::PROD_W){prod_reg[msq_pkg::PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            row_base_reg <= row_base_next[msq_pkg::ADDR_W-1:0];
        end
        if (cmd.issue)
        begin
            ptr_a_reg <= addr_a;
            ptr_b_reg <= addr_b;
        end
        s1_first_reg <= cmd.k_first;
        s1_last_reg  <= cmd.k_last;
        s1_end_reg   <= cmd.row_end;
        s1_col_reg   <= cmd.col;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_end_reg   <= s1_end_reg;
        s2_col_reg   <= s1_col_reg;
        prod_reg     <= rd_a_reg * rd_b_reg;
        if (s2_valid_reg)
        begin
            acc_reg <= sum;
        end
        if (s2_valid_reg && s2_last_reg)
        begin
            row_index_reg    <= cmd.row;
            column_index_reg <= s2_col_reg;
            product_sum_reg  <= sum;
            last_reg         <= s2_end_reg;
            status_reg       <= msq_pkg::STATUS_OK;
        end
        else if (cmd.emit_status)
        begin
            row_index_reg    <= '0;
            column_index_reg <= '0;
            product_sum_reg  <= '0;
            last_reg         <= 1'b1;
            status_reg       <= cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            strobe_reg   <= (s2_valid_reg && s2_last_reg) || cmd.emit_status;
        end
    end

    assign strobe       = strobe_reg;
    assign row_index    = row_index_reg;
    assign column_index = column_index_reg;
    assign product_sum  = product_sum_reg;
    assign last         = last_reg;
    assign status       = status_reg;

    `ASSERT_HOLDS(a_no_write_during_mac, clk, rst_n, !(cmd.issue && cmd.wr_en))
    `ASSERT_HOLDS(a_no_status_during_mac, clk, rst_n, !(cmd.emit_status && s2_valid_reg))
    `ASSERT_IMPLY(a_status_shape, clk, rst_n,
                  strobe_reg && (status_reg != msq_pkg::STATUS_OK),
                  last_reg && (product_sum_reg == '0))

endmodule

`default_nettype wire

// ----- hdl/matrix_square_row_engine_top.sv -----
// top level of the matrix square row engine
`default_nettype none

// Squares an n-by-n signed Q8.8 matrix one result row per compute request.
// A load request (kind 0) is taken while busy stays low, so loads
// can follow back to back. A compute request (kind 1) for a valid row holds
// busy high through a setup state that forms the row base address, a run
// state that feeds the single multiply-accumulate unit from the
// two-read-port element store, and a pipeline drain state; its n results
// leave one per column. A compute request that finds the matrix not fully
// loaded or the row range finished gives one status result in the next cycle.
// Every result is on the ports for exactly one cycle with strobe high and
// cannot be held off. Configuration is taken whenever cfg_valid is high and
// should only be written while the block is idle.
module matrix_square_row_engine_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               kind,
    input  wire logic signed [msq_pkg::ELEM_W-1:0]  element,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [msq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [msq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                    strobe,
    output logic [msq_pkg::IDX_W-1:0]               row_index,
    output logic [msq_pkg::IDX_W-1:0]               column_index,
    output logic signed [msq_pkg::SUM_W-1:0]        product_sum,
    output logic                                    last,
    output logic [1:0]                              status
);

    msq_pkg::dp_cmd_t  cmd;
    msq_pkg::status_t  status_code;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    msq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .cfg_valid (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cmd       (cmd)
    );

    msq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .element      (element),
        .strobe       (strobe),
        .row_index    (row_index),
        .column_index (column_index),
        .product_sum  (product_sum),
        .last         (last),
        .status       (status_code)
    );

    assign status = status_code;

endmodule

`default_nettype wire
